@@ rtl/mbrp_pkg.sv @@
// Shared types, constants and sequencer states for the MBR partition table parser.
`default_nettype none
package mbrp_pkg;

	localparam int ENTRY_COUNT  = 4;
	localparam int ENTRY_IDX_W  = $clog2(ENTRY_COUNT);
	localparam int POS_W        = 10;
	localparam int SECTOR_BYTES = 512;
	localparam int TABLE_START  = 446;
	localparam int ENTRY_BYTES  = 16;
	localparam int SIG_POS      = 510;
	localparam int SSIZE_W      = 13;
	localparam int LBA_W        = 32;
	localparam int BYTES_W      = 44;
	localparam int COUNT_W      = 3;

	localparam logic [7:0]         BOOT_STATUS   = 8'h80;
	localparam logic [7:0]         SIG_LOW       = 8'h55;
	localparam logic [7:0]         SIG_HIGH      = 8'hAA;
	localparam logic [SSIZE_W-1:0] SSIZE_RESET   = 13'd512;
	localparam logic               KIND_PART     = 1'b0;
	localparam logic               KIND_CLOSE    = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NO_SIG = 2'd1,
		STAT_SHORT  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_LEN,
		ST_EMIT,
		ST_CLOSE
	} state_t;

	typedef struct packed {
		logic             boot;
		logic [7:0]       part_type;
		logic [LBA_W-1:0] start;
		logic [LBA_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic short_sector;
		logic sig_bad;
	} cap_status_t;

endpackage
`default_nettype wire

@@ rtl/mbr_partition_table_parser.sv @@
// Top level of the MBR partition table parser: byte intake, sequencer and record output.
//
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+------------------------------------------
// input    | start & !busy                    | data_byte, end_of_sector
// config   | blk_size_we                      | blk_size
// result   | result_valid (one-cycle strobe)  | record_kind .. last_record
//
// Every byte that is not the last is taken in while busy stays low. After the final byte
// busy rises: each non-empty entry walks ST_CHECK, ST_MUL_LEN and ST_EMIT (two passes
// through the one shared multiplier, then the record), each empty entry ST_CHECK alone,
// and the closing record ST_CLOSE. A bad or short sector goes straight to the closing
// record. Reset clears the byte counter, signature bytes and sequencer and sets the sector
// size to 512. The receiver cannot stall; each record shows for one cycle.
`default_nettype none
module mbr_partition_table_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            end_of_sector,
	input  wire logic                            blk_size_we,
	input  wire logic [mbrp_pkg::SSIZE_W-1:0]    blk_size,
	output logic                                 result_valid,
	output logic                                 record_kind,
	output logic                                 bootable,
	output logic      [7:0]                      part_type,
	output logic      [mbrp_pkg::LBA_W-1:0]      start_lba,
	output logic      [mbrp_pkg::LBA_W-1:0]      length_sectors,
	output logic      [mbrp_pkg::BYTES_W-1:0]    start_bytes,
	output logic      [mbrp_pkg::BYTES_W-1:0]    byte_length,
	output logic      [mbrp_pkg::COUNT_W-1:0]    entry_total,
	output logic      [1:0]                      status_code,
	output logic                                 last_record
);
	import mbrp_pkg::*;

	state_t                 state_q, state_d;
	logic [SSIZE_W-1:0]     blk_size_q;
	logic [ENTRY_IDX_W-1:0] idx_q;
	logic [COUNT_W-1:0]     count_q;
	status_t                status_q;
	logic [BYTES_W-1:0]     start_bytes_q;

	logic                   accept;
	logic                   last_idx;
	logic                   entry_empty;
	entry_t                 entry;
	cap_status_t            cap_status;
	logic [LBA_W-1:0]       mul_lba;
	logic [BYTES_W-1:0]     mul_product;

	assign busy        = state_q != ST_IDLE;
	assign accept      = start && !busy;
	assign last_idx    = idx_q == ENTRY_IDX_W'(ENTRY_COUNT - 1);
	assign entry_empty = (entry.part_type == 8'd0) && (entry.length == '0);

	mbrp_capture u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_sector(end_of_sector),
		.rd_idx       (idx_q),
		.entry        (entry),
		.cap_status   (cap_status)
	);

	// Feed start LBA while checking an entry, length on the following cycle.
	assign mul_lba = (state_q == ST_CHECK) ? entry.start : entry.length;

	mbrp_mul u_mul (
		.clk        (clk),
		.lba        (mul_lba),
		.blk_size   (blk_size_q),
		.product    (mul_product)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && end_of_sector) begin
					if (cap_status.short_sector || cap_status.sig_bad)
						state_d = ST_CLOSE;
					else
						state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!entry_empty)
					state_d = ST_MUL_LEN;
				else if (last_idx)
					state_d = ST_CLOSE;
			end
			ST_MUL_LEN: state_d = ST_EMIT;
			ST_EMIT:    state_d = last_idx ? ST_CLOSE : ST_CHECK;
			ST_CLOSE:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			blk_size_q    <= SSIZE_RESET;
			idx_q         <= '0;
			count_q       <= '0;
			status_q      <= STAT_OK;
		end else begin
			state_q <= state_d;
			if (blk_size_we)
				blk_size_q <= blk_size;
			unique case (state_q)
				ST_IDLE: begin
					// Latch the sector verdict and rewind the entry walk.
					if (accept && end_of_sector) begin
						idx_q   <= '0;
						count_q <= '0;
						priority if (cap_status.short_sector)
							status_q <= STAT_SHORT;
						else if (cap_status.sig_bad)
							status_q <= STAT_NO_SIG;
						else
							status_q <= STAT_OK;
					end
				end
				ST_CHECK: begin
					// Skip an empty entry.
					if (entry_empty && !last_idx)
						idx_q <= idx_q + ENTRY_IDX_W'(1);
				end
				ST_EMIT: begin
					count_q <= count_q + COUNT_W'(1);
					if (!last_idx)
						idx_q <= idx_q + ENTRY_IDX_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the start product while the multiplier works on the length.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_LEN)
			start_bytes_q <= mul_product;
	end

	// Outputs.
	always_comb begin
		result_valid   = 1'b0;
		record_kind    = KIND_PART;
		bootable       = 1'b0;
		part_type      = '0;
		start_lba      = '0;
		length_sectors = '0;
		start_bytes    = '0;
		byte_length    = '0;
		entry_total    = '0;
		status_code    = STAT_OK;
		last_record    = 1'b0;
		unique case (state_q)
			ST_EMIT: begin
				result_valid   = 1'b1;
				bootable       = entry.boot;
				part_type      = entry.part_type;
				start_lba      = entry.start;
				length_sectors = entry.length;
				start_bytes    = start_bytes_q;
				byte_length    = mul_product;
			end
			ST_CLOSE: begin
				result_valid = 1'b1;
				record_kind  = KIND_CLOSE;
				entry_total  = count_q;
				status_code  = status_q;
				last_record  = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/mbrp_capture.sv @@
// Byte position counter, partition entry stores and boot signature capture.
`default_nettype none
module mbrp_capture (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             end_of_sector,
	input  wire logic [mbrp_pkg::ENTRY_IDX_W-1:0] rd_idx,
	output mbrp_pkg::entry_t                      entry,
	output mbrp_pkg::cap_status_t                 cap_status
);
	import mbrp_pkg::*;

	logic [POS_W-1:0] byte_position_q;
	logic [7:0]       signature_low_q;
	logic [7:0]       signature_high_q;
	logic [8:0]       entry_boot_and_type_q [ENTRY_COUNT];
	logic [LBA_W-1:0] entry_start_q         [ENTRY_COUNT];
	logic [LBA_W-1:0] entry_length_q        [ENTRY_COUNT];

	logic [POS_W-1:0]       rel;
	logic [ENTRY_IDX_W-1:0] e;
	logic [3:0]             off;
	logic                   in_table;
	logic                   counting;
	logic [4:0]             lane;
	logic [7:0]             high_now;

	assign counting = byte_position_q < POS_W'(SECTOR_BYTES);
	assign rel      = byte_position_q - POS_W'(TABLE_START);
	assign e        = rel[ENTRY_IDX_W+3:4];
	assign off      = rel[3:0];
	assign lane     = {off[1:0], 3'b000};
	assign in_table = (byte_position_q >= POS_W'(TABLE_START)) &&
	                  (byte_position_q < POS_W'(TABLE_START + ENTRY_COUNT * ENTRY_BYTES));

	// Status as it stands once the current byte has been taken in.
	assign high_now = (byte_position_q == POS_W'(SIG_POS + 1)) ? data_byte : signature_high_q;
	always_comb begin
		cap_status.short_sector = byte_position_q < POS_W'(SECTOR_BYTES - 1);
		cap_status.sig_bad      = (signature_low_q != SIG_LOW) || (high_now != SIG_HIGH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			signature_low_q  <= '0;
			signature_high_q <= '0;
		end else if (accept) begin
			if (end_of_sector) begin
				byte_position_q  <= '0;
				signature_low_q  <= '0;
				signature_high_q <= '0;
			end else if (counting) begin
				byte_position_q <= byte_position_q + POS_W'(1);
				if (byte_position_q == POS_W'(SIG_POS))
					signature_low_q <= data_byte;
				if (byte_position_q == POS_W'(SIG_POS + 1))
					signature_high_q <= data_byte;
			end
		end
	end

	// Entry stores hold no reset; they are fully written before any read.
	always_ff @(posedge clk) begin
		if (accept && counting && in_table) begin
			if (off == 4'd0)
				entry_boot_and_type_q[e][8] <= data_byte == BOOT_STATUS;
			else if (off == 4'd4)
				entry_boot_and_type_q[e][7:0] <= data_byte;
			else if (off[3:2] == 2'b10)
				entry_start_q[e][lane +: 8] <= data_byte;
			else if (off[3:2] == 2'b11)
				entry_length_q[e][lane +: 8] <= data_byte;
		end
	end

	always_comb begin
		entry.boot      = entry_boot_and_type_q[rd_idx][8];
		entry.part_type = entry_boot_and_type_q[rd_idx][7:0];
		entry.start     = entry_start_q[rd_idx];
		entry.length    = entry_length_q[rd_idx];
	end

endmodule
`default_nettype wire

@@ rtl/mbrp_mul.sv @@
// Shared registered multiplier that scales sector counts to byte counts.
`default_nettype none
module mbrp_mul (
	input  wire logic                           clk,
	input  wire logic [mbrp_pkg::LBA_W-1:0]     lba,
	input  wire logic [mbrp_pkg::SSIZE_W-1:0]   blk_size,
	output logic      [mbrp_pkg::BYTES_W-1:0]   product
);
	import mbrp_pkg::*;

	logic [LBA_W+SSIZE_W-1:0] full_prod;
	logic [BYTES_W-1:0]       product_q;

	assign full_prod = {{SSIZE_W{1'b0}}, lba} * {{LBA_W{1'b0}}, blk_size};

	// Keep the low bits; oversized sector sizes wrap.
	always_ff @(posedge clk) begin
		product_q <= full_prod[BYTES_W-1:0];
	end

	assign product = product_q;

endmodule
`default_nettype wire

@@ rtl/mbrp_parser_top.sv @@
// Empty unit; the parser's top level is in mbr_partition_table_parser.sv.
`default_nettype none
`default_nettype wire

@@ tb/sv/tb_mbr_partition_table_parser.sv @@
// Self-checking testbench for the MBR partition table parser: directed sectors, then random ones.
`timescale 1ns / 1ps

module tb_mbr_partition_table_parser;
	import mbrp_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_SECTORS = 44;
	localparam int MAX_GAP        = 11;
	localparam int BUF_BYTES      = 1024;
	localparam int IDLE_SETTLE    = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int PLAN_ROWS      = 15;

	// How the two signature bytes of a stimulus sector are laid down.
	typedef enum logic [2:0] {
		SIG_GOOD,
		SIG_LOW_BAD,
		SIG_HIGH_BAD,
		SIG_SWAPPED,
		SIG_RANDOM
	} sig_form_t;

	// How the four partition entries of a stimulus sector are laid down.
	typedef enum logic [1:0] {
		TBL_EMPTY,
		TBL_EXTREME,
		TBL_EDGE,
		TBL_RANDOM
	} table_form_t;

	// One directed sector: length, optional sector size load, layout, and
	// a typed closing record where it can be read off at a glance.
	typedef struct packed {
		logic [10:0]        nbytes;
		logic               set_ssize;
		logic [SSIZE_W-1:0] ssize;
		sig_form_t          sig;
		table_form_t        tbl;
		logic               typed;
		status_t            exp_status;
		logic [COUNT_W-1:0] exp_count;
	} sector_row_t;

	typedef struct packed {
		logic               kind;
		logic               boot;
		logic [7:0]         ptype;
		logic [LBA_W-1:0]   lba;
		logic [LBA_W-1:0]   sectors;
		logic [BYTES_W-1:0] offset;
		logic [BYTES_W-1:0] span;
		logic [COUNT_W-1:0] count;
		status_t            status;
		logic               last;
	} mbr_record_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               start          = 1'b0;
	logic [7:0]         data_byte      = 8'd0;
	logic               end_of_sector  = 1'b0;
	logic               blk_size_we    = 1'b0;
	logic [SSIZE_W-1:0] blk_size       = SSIZE_RESET;
	logic               busy;
	logic               result_valid;
	logic               record_kind;
	logic               bootable;
	logic [7:0]         part_type;
	logic [LBA_W-1:0]   start_lba;
	logic [LBA_W-1:0]   length_sectors;
	logic [BYTES_W-1:0] start_bytes;
	logic [BYTES_W-1:0] byte_length;
	logic [COUNT_W-1:0] entry_total;
	logic [1:0]         status_code;
	logic               last_record;

	mbr_partition_table_parser u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.data_byte      (data_byte),
		.end_of_sector  (end_of_sector),
		.blk_size_we    (blk_size_we),
		.blk_size       (blk_size),
		.result_valid   (result_valid),
		.record_kind    (record_kind),
		.bootable       (bootable),
		.part_type      (part_type),
		.start_lba      (start_lba),
		.length_sectors (length_sectors),
		.start_bytes    (start_bytes),
		.byte_length    (byte_length),
		.entry_total    (entry_total),
		.status_code    (status_code),
		.last_record    (last_record)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Our own copy of the parser state; it mirrors the block byte by byte.
	int                 model_pos   = 0;
	entry_t             model_ent [ENTRY_COUNT];
	logic [7:0]         model_sig_lo = 8'd0;
	logic [7:0]         model_sig_hi = 8'd0;
	logic [SSIZE_W-1:0] model_ssize  = SSIZE_RESET;

	// Records the parser owes us, oldest first.
	mbr_record_t due_records [$];
	mbr_record_t want;
	int          mismatch_count = 0;

	// Typed closing record for directed rows; replaces the predicted one.
	logic               typed_close_on = 1'b0;
	status_t            typed_status   = STAT_OK;
	logic [COUNT_W-1:0] typed_count    = '0;

	logic [7:0]  sector_bytes [BUF_BYTES];
	sector_row_t sector_plan [PLAN_ROWS];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, exp_val);
		mismatch_count++;
	endtask

	// Advance the mirrored parser by one accepted byte; on the final byte,
	// queue the partition records and the closing record it must produce.
	task automatic parse_table_byte(input logic [7:0] b, input logic eos);
		mbr_record_t        rec;
		int                 rel;
		int                 e;
		int                 off;
		logic [COUNT_W-1:0] n;
		status_t            st;
		if (model_pos < SECTOR_BYTES) begin
			if (model_pos >= TABLE_START && model_pos < TABLE_START + ENTRY_COUNT * ENTRY_BYTES) begin
				rel = model_pos - TABLE_START;
				e   = rel / ENTRY_BYTES;
				off = rel % ENTRY_BYTES;
				if (off == 0)
					model_ent[e].boot = (b == BOOT_STATUS);
				else if (off == 4)
					model_ent[e].part_type = b;
				else if (off >= 8 && off < 12)
					model_ent[e].start[(off - 8) * 8 +: 8] = b;
				else if (off >= 12)
					model_ent[e].length[(off - 12) * 8 +: 8] = b;
			end else if (model_pos == SIG_POS) begin
				model_sig_lo = b;
			end else if (model_pos == SIG_POS + 1) begin
				model_sig_hi = b;
			end
			model_pos++;
		end
		if (!eos)
			return;

		n  = '0;
		st = STAT_OK;
		if (model_pos < SECTOR_BYTES) begin
			st = STAT_SHORT;
		end else if (model_sig_lo != SIG_LOW || model_sig_hi != SIG_HIGH) begin
			st = STAT_NO_SIG;
		end else begin
			for (e = 0; e < ENTRY_COUNT; e++) begin
				// Skip an entry only when both type and length are zero.
				if (model_ent[e].part_type == 8'd0 && model_ent[e].length == '0)
					continue;
				rec         = '0;
				rec.kind    = KIND_PART;
				rec.boot    = model_ent[e].boot;
				rec.ptype   = model_ent[e].part_type;
				rec.lba     = model_ent[e].start;
				rec.sectors = model_ent[e].length;
				// Products keep only their low 44 bits.
				rec.offset  = BYTES_W'(model_ent[e].start) * BYTES_W'(model_ssize);
				rec.span    = BYTES_W'(model_ent[e].length) * BYTES_W'(model_ssize);
				due_records.push_back(rec);
				n++;
			end
		end
		rec        = '0;
		rec.kind   = KIND_CLOSE;
		rec.count  = typed_close_on ? typed_count : n;
		rec.status = typed_close_on ? typed_status : st;
		rec.last   = 1'b1;
		due_records.push_back(rec);

		// The run is over: rewind for the next sector.
		model_pos    = 0;
		model_sig_lo = 8'd0;
		model_sig_hi = 8'd0;
	endtask

	// Offer one byte, hold it until accepted, then drop start for the requested gap.
	task automatic send_byte(input logic [7:0] b, input logic eos, input int gap);
		start         <= 1'b1;
		data_byte     <= b;
		end_of_sector <= eos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		parse_table_byte(b, eos);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start, let every owed record arrive, then let the sequencer settle.
	task automatic wait_idle();
		start <= 1'b0;
		while (due_records.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic load_sector_size(input logic [SSIZE_W-1:0] v);
		blk_size_we <= 1'b1;
		blk_size    <= v;
		@(posedge clk);
		model_ssize  = v;
		blk_size_we <= 1'b0;
	endtask

	task automatic put_entry(input int e, input logic [7:0] status, input logic [7:0] ptype,
			input logic [31:0] lba, input logic [31:0] len);
		int base;
		int k;
		base = TABLE_START + e * ENTRY_BYTES;
		sector_bytes[base]     = status;
		sector_bytes[base + 4] = ptype;
		for (k = 0; k < 4; k++) begin
			sector_bytes[base + 8 + k]  = lba[k * 8 +: 8];
			sector_bytes[base + 12 + k] = len[k * 8 +: 8];
		end
	endtask

	// Lay down a sector: random filler, then the table and signature forms.
	// Except in the empty table, bytes 1-3 and 5-7 of each entry (the CHS fields) stay random.
	task automatic build_sector(input int nbytes, input sig_form_t sig, input table_form_t tbl);
		int          i;
		int          pick;
		logic [7:0]  status;
		logic [7:0]  ptype;
		logic [31:0] lba;
		logic [31:0] len;
		for (i = 0; i < nbytes; i++)
			sector_bytes[i] = 8'($urandom);
		case (tbl)
			TBL_EMPTY: begin
				for (i = 0; i < ENTRY_COUNT * ENTRY_BYTES; i++)
					sector_bytes[TABLE_START + i] = 8'd0;
			end
			TBL_EXTREME: begin
				for (i = 0; i < ENTRY_COUNT; i++)
					put_entry(i, BOOT_STATUS, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			end
			TBL_EDGE: begin
				// Zero type with a length, a type with zero length, a skipped entry
				// that still has a start, and status bytes either side of the boot flag.
				put_entry(0, BOOT_STATUS, 8'h00, 32'h0000_0000, 32'h0000_0001);
				put_entry(1, 8'h81, 8'h07, 32'h1234_5678, 32'h0000_0000);
				put_entry(2, BOOT_STATUS, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
				put_entry(3, 8'h7F, 8'h83, 32'h8000_0000, 32'h0001_0000);
			end
			default: begin
				for (i = 0; i < ENTRY_COUNT; i++) begin
					pick   = $urandom_range(0, 7);
					status = $urandom_range(0, 1) ? BOOT_STATUS : 8'($urandom);
					ptype  = 8'($urandom);
					lba    = $urandom;
					len    = $urandom;
					case (pick)
						0, 1: begin
							ptype = 8'd0;
							len   = '0;
						end
						2: ptype = 8'd0;
						3: len = '0;
						4: begin
							lba = '1;
							len = '1;
						end
						5: len = 32'($urandom_range(1, 4096));
						default: ;
					endcase
					put_entry(i, status, ptype, lba, len);
				end
			end
		endcase
		case (sig)
			SIG_GOOD: begin
				sector_bytes[SIG_POS]     = SIG_LOW;
				sector_bytes[SIG_POS + 1] = SIG_HIGH;
			end
			SIG_LOW_BAD: begin
				sector_bytes[SIG_POS]     = SIG_LOW ^ 8'h01;
				sector_bytes[SIG_POS + 1] = SIG_HIGH;
			end
			SIG_HIGH_BAD: begin
				sector_bytes[SIG_POS]     = SIG_LOW;
				sector_bytes[SIG_POS + 1] = SIG_HIGH ^ 8'h80;
			end
			SIG_SWAPPED: begin
				sector_bytes[SIG_POS]     = SIG_HIGH;
				sector_bytes[SIG_POS + 1] = SIG_LOW;
			end
			default: ;
		endcase
	endtask

	// Stream a sector. Each sector gets its own pacing: back to back,
	// gaps on every byte, or only now and then. The final byte always
	// draws a random gap, possibly zero, so that pauses also land while the block is emitting.
	task automatic send_sector(input int nbytes, input sig_form_t sig, input table_form_t tbl);
		int i;
		int pace;
		int gap;
		build_sector(nbytes, sig, tbl);
		pace = $urandom_range(0, 2);
		for (i = 0; i < nbytes; i++) begin
			if (i == nbytes - 1)
				gap = $urandom_range(0, MAX_GAP);
			else if (pace == 1)
				gap = $urandom_range(0, MAX_GAP);
			else if (pace == 2 && $urandom_range(0, 15) == 0)
				gap = $urandom_range(1, MAX_GAP);
			else
				gap = 0;
			send_byte(sector_bytes[i], i == nbytes - 1, gap);
		end
	endtask

	// Check each strobed record against the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (due_records.size() == 0) begin
				flag_mismatch("record with none owed", 64'({record_kind, status_code}),
					64'(0));
			end else begin
				want = due_records.pop_front();
				if (record_kind !== want.kind)
					flag_mismatch("record_kind", 64'(record_kind), 64'(want.kind));
				if (bootable !== want.boot)
					flag_mismatch("bootable", 64'(bootable), 64'(want.boot));
				if (part_type !== want.ptype)
					flag_mismatch("part_type", 64'(part_type), 64'(want.ptype));
				if (start_lba !== want.lba)
					flag_mismatch("start_lba", 64'(start_lba), 64'(want.lba));
				if (length_sectors !== want.sectors)
					flag_mismatch("length_sectors", 64'(length_sectors), 64'(want.sectors));
				if (start_bytes !== want.offset)
					flag_mismatch("start_bytes", 64'(start_bytes), 64'(want.offset));
				if (byte_length !== want.span)
					flag_mismatch("byte_length", 64'(byte_length), 64'(want.span));
				if (entry_total !== want.count)
					flag_mismatch("entry_total", 64'(entry_total), 64'(want.count));
				if (status_code !== want.status)
					flag_mismatch("status_code", 64'(status_code), 64'(want.status));
				if (last_record !== want.last)
					flag_mismatch("last_record", 64'(last_record), 64'(want.last));
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("tb_mbr_partition_table_parser: done, errors");
		$finish;
	end

	initial begin
		int          s;
		int          k;
		int          pick;
		int          nbytes;
		sector_row_t row;
		logic [SSIZE_W-1:0] ssize_pick;

		for (k = 0; k < ENTRY_COUNT; k++)
			model_ent[k] = '0;

		// Directed sectors. Rows with typed = 1 carry their closing record.
		sector_plan = '{
			// a lone final byte right after reset
			'{11'd1,    1'b0, 13'd0,    SIG_RANDOM,   TBL_RANDOM,  1'b1, STAT_SHORT,  3'd0},
			'{11'd512,  1'b0, 13'd0,    SIG_GOOD,     TBL_EMPTY,   1'b1, STAT_OK,     3'd0},
			'{11'd512,  1'b0, 13'd0,    SIG_GOOD,     TBL_EXTREME, 1'b0, STAT_OK,     3'd0},
			'{11'd512,  1'b0, 13'd0,    SIG_GOOD,     TBL_EDGE,    1'b0, STAT_OK,     3'd0},
			// one byte short of a sector
			'{11'd511,  1'b0, 13'd0,    SIG_GOOD,     TBL_EXTREME, 1'b1, STAT_SHORT,  3'd0},
			'{11'd512,  1'b0, 13'd0,    SIG_LOW_BAD,  TBL_EXTREME, 1'b1, STAT_NO_SIG, 3'd0},
			'{11'd512,  1'b0, 13'd0,    SIG_HIGH_BAD, TBL_EXTREME, 1'b1, STAT_NO_SIG, 3'd0},
			'{11'd512,  1'b0, 13'd0,    SIG_SWAPPED,  TBL_EXTREME, 1'b1, STAT_NO_SIG, 3'd0},
			// bytes past the sector end are dropped
			'{11'd700,  1'b0, 13'd0,    SIG_GOOD,     TBL_EDGE,    1'b0, STAT_OK,     3'd0},
			'{11'd512,  1'b1, 13'd4096, SIG_GOOD,     TBL_EXTREME, 1'b0, STAT_OK,     3'd0},
			// oversized sector size: products wrap at 44 bits
			'{11'd512,  1'b1, 13'd8191, SIG_GOOD,     TBL_EXTREME, 1'b0, STAT_OK,     3'd0},
			'{11'd512,  1'b1, 13'd0,    SIG_GOOD,     TBL_EDGE,    1'b0, STAT_OK,     3'd0},
			'{11'd512,  1'b1, 13'd1,    SIG_GOOD,     TBL_RANDOM,  1'b0, STAT_OK,     3'd0},
			'{11'd2,    1'b1, 13'd512,  SIG_RANDOM,   TBL_RANDOM,  1'b1, STAT_SHORT,  3'd0},
			'{11'd1024, 1'b0, 13'd0,    SIG_GOOD,     TBL_EXTREME, 1'b0, STAT_OK,     3'd0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; load the sector size only once idle.
		for (s = 0; s < PLAN_ROWS; s++) begin
			row = sector_plan[s];
			if (row.set_ssize) begin
				wait_idle();
				load_sector_size(row.ssize);
			end
			typed_close_on = row.typed;
			typed_status   = row.exp_status;
			typed_count    = row.exp_count;
			send_sector(row.nbytes, row.sig, row.tbl);
			typed_close_on = 1'b0;
		end

		// Random sectors: mostly well-formed tables with random content,
		// the rest short, long or with a broken signature.
		for (s = 0; s < RANDOM_SECTORS; s++) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 5))
					0: ssize_pick = 13'd512;
					1: ssize_pick = 13'd1024;
					2: ssize_pick = 13'd2048;
					3: ssize_pick = 13'd4096;
					4: ssize_pick = 13'd8191;
					default: ssize_pick = 13'($urandom_range(0, 8191));
				endcase
				wait_idle();
				load_sector_size(ssize_pick);
			end else if ($urandom_range(0, 7) == 0) begin
				// hold off until the parser has drained
				wait_idle();
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(513, BUF_BYTES) : SECTOR_BYTES;
				send_sector(nbytes, SIG_GOOD, TBL_RANDOM);
			end else if (pick < 72) begin
				send_sector(SECTOR_BYTES, sig_form_t'($urandom_range(1, 4)), TBL_RANDOM);
			end else if (pick < 88) begin
				send_sector($urandom_range(1, SECTOR_BYTES - 1), SIG_GOOD, TBL_RANDOM);
			end else begin
				send_sector($urandom_range(513, BUF_BYTES), SIG_RANDOM, TBL_RANDOM);
			end
		end

		// Drain, then give stray records a chance to show up.
		start <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && due_records.size() != 0; k++)
			@(posedge clk);
		if (due_records.size() != 0)
			flag_mismatch("records never produced", 64'(due_records.size()), 64'(0));
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_mbr_partition_table_parser: done, clean");
		else
			$display("tb_mbr_partition_table_parser: done, errors");
		$finish;
	end

endmodule

@@ mbr_partition_table_parser.f @@
rtl/mbrp_pkg.sv
rtl/mbrp_capture.sv
rtl/mbrp_mul.sv
rtl/mbrp_parser_top.sv
rtl/mbr_partition_table_parser.sv
tb/sv/tb_mbr_partition_table_parser.sv
